FILE: hw/rtl/dtmt_pkg.sv
// Package for the drop-test minimum-trials core: widths, the payload structs,
// the sequencer state type and the row-memory request/response structs.
// No dependencies.
`default_nettype none

package dtmt_pkg;

    localparam int MAX_FLOORS = 65536;
    localparam int ROW_DEPTH  = MAX_FLOORS + 1;
    localparam int ADDR_W     = $clog2(ROW_DEPTH);
    localparam int VAL_W      = 16;
    localparam int FLOORS_W   = 17;
    localparam int PHONES_W   = 6;
    localparam int K_W        = $clog2(ADDR_W + 1);

    typedef struct packed {
        logic [FLOORS_W-1:0] floors;
        logic [PHONES_W-1:0] phones;
    } t_in_req;

    typedef struct packed {
        logic [VAL_W-1:0] tests;
        logic             impossible;
    } t_out_req;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_ROW0,
        ST_ROW1,
        ST_CELL_RD,
        ST_CELL_WR,
        ST_FIN_RD,
        ST_FIN_CAP,
        ST_DONE
    } t_state;

    // Row memory control: one write port, two reads on the current row and
    // two on the previous row.
    typedef struct packed {
        logic              we;
        logic              wbank;
        logic [ADDR_W-1:0] waddr;
        logic [VAL_W-1:0]  wdata;
        logic              prev_bank;
        logic [ADDR_W-1:0] cur_a0;
        logic [ADDR_W-1:0] cur_a1;
        logic [ADDR_W-1:0] prev_a0;
        logic [ADDR_W-1:0] prev_a1;
    } t_mem_ctl;

    typedef struct packed {
        logic [VAL_W-1:0] cur_d0;
        logic [VAL_W-1:0] cur_d1;
        logic [VAL_W-1:0] prev_d0;
        logic [VAL_W-1:0] prev_d1;
    } t_mem_rsp;

endpackage

`default_nettype wire

FILE: hw/rtl/dtmt_row_mem.sv
// Ping-pong row store: two banks of ROW_DEPTH entries, each written at one
// address and read at two, read data registered. Depends on dtmt_pkg.
`default_nettype none

module dtmt_row_mem (
    input  wire              i_clk,
    input  dtmt_pkg::t_mem_ctl i_ctl,
    output dtmt_pkg::t_mem_rsp o_rsp
);
    import dtmt_pkg::*;

    logic [VAL_W-1:0] bank0 [ROW_DEPTH];
    logic [VAL_W-1:0] bank1 [ROW_DEPTH];

    logic [ADDR_W-1:0] b0_a0, b0_a1, b1_a0, b1_a1;
    logic [VAL_W-1:0]  r_b0_q0, r_b0_q1, r_b1_q0, r_b1_q1;

    // Bank that is not the previous row holds the current row.
    always_comb begin
        if (i_ctl.prev_bank) begin
            b0_a0 = i_ctl.cur_a0;
            b0_a1 = i_ctl.cur_a1;
            b1_a0 = i_ctl.prev_a0;
            b1_a1 = i_ctl.prev_a1;
        end else begin
            b0_a0 = i_ctl.prev_a0;
            b0_a1 = i_ctl.prev_a1;
            b1_a0 = i_ctl.cur_a0;
            b1_a1 = i_ctl.cur_a1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.we && !i_ctl.wbank) begin
            bank0[i_ctl.waddr] <= i_ctl.wdata;
        end
        r_b0_q0 <= bank0[b0_a0];
        r_b0_q1 <= bank0[b0_a1];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.we && i_ctl.wbank) begin
            bank1[i_ctl.waddr] <= i_ctl.wdata;
        end
        r_b1_q0 <= bank1[b1_a0];
        r_b1_q1 <= bank1[b1_a1];
    end

    always_comb begin
        if (i_ctl.prev_bank) begin
            o_rsp.cur_d0  = r_b0_q0;
            o_rsp.cur_d1  = r_b0_q1;
            o_rsp.prev_d0 = r_b1_q0;
            o_rsp.prev_d1 = r_b1_q1;
        end else begin
            o_rsp.cur_d0  = r_b1_q0;
            o_rsp.cur_d1  = r_b1_q1;
            o_rsp.prev_d0 = r_b0_q0;
            o_rsp.prev_d1 = r_b0_q1;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/dtmt_cell.sv
// Shared cell unit: evaluates the cost at the current split and the next one
// and picks the smaller. Depends on dtmt_pkg.
`default_nettype none

module dtmt_cell (
    input  dtmt_pkg::t_mem_rsp         i_rsp,
    output logic [dtmt_pkg::VAL_W-1:0] o_value,
    output logic                       o_step
);
    import dtmt_pkg::*;

    logic [VAL_W:0] here, next;

    always_comb begin
        here = {1'b0, (i_rsp.cur_d0 > i_rsp.prev_d0) ? i_rsp.cur_d0 : i_rsp.prev_d0}
               + (VAL_W+1)'(1);
        next = {1'b0, (i_rsp.cur_d1 > i_rsp.prev_d1) ? i_rsp.cur_d1 : i_rsp.prev_d1}
               + (VAL_W+1)'(1);
        // Advance the split only on a strictly smaller cost.
        o_step  = (next < here);
        o_value = o_step ? next[VAL_W-1:0] : here[VAL_W-1:0];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/drop_test_min_trials_core.sv
// Drop-test minimum-trials core: worst-case drop tests for (floors, phones).
// Zero or one floor, or zero phones, go straight to ST_DONE; otherwise the
// core builds the one-phone row, then rows 2 to k (n = floors, k = effective
// phones, at most 17 at n = 65536). Per DP cell, ST_CELL_RD issues the
// registered row-memory read, then ST_CELL_WR does the compare and write.
// One request at a time; reset (synchronous, active low) returns to idle.
`default_nettype none

module drop_test_min_trials_core (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  dtmt_pkg::t_in_req   i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output dtmt_pkg::t_out_req  o_out_data
);
    import dtmt_pkg::*;

    // Sequencer registers
    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_n, n_n;          // saturated floor count
    logic [K_W-1:0]    r_k, n_k;          // effective phone count
    logic [K_W-1:0]    r_p, n_p;          // row being built
    logic [ADDR_W-1:0] r_f, n_f;          // floor index within the row
    logic [ADDR_W-1:0] r_split, n_split;  // monotone split pointer
    logic              r_prev_bank, n_prev_bank;
    logic [VAL_W-1:0]  r_tests, n_tests;
    logic              r_imposs, n_imposs;
    logic              r_out_valid, n_out_valid;
    t_out_req          r_out_data, n_out_data;

    t_mem_ctl          mem_ctl;
    t_mem_rsp          mem_rsp;
    logic [VAL_W-1:0]  cell_value;
    logic              cell_step;

    // Request decode
    logic [ADDR_W-1:0] floors_sat;
    logic [K_W-1:0]    bit_len;
    logic [PHONES_W-1:0] k_eff;

    dtmt_row_mem u_mem (
        .i_clk (i_clk),
        .i_ctl (mem_ctl),
        .o_rsp (mem_rsp)
    );

    dtmt_cell u_cell (
        .i_rsp   (mem_rsp),
        .o_value (cell_value),
        .o_step  (cell_step)
    );

    // Saturate floors, take its bit length, and cut phones to it: with
    // 2^(len-1) <= n < 2^len, 2^k exceeds n exactly when k >= len.
    always_comb begin
        if ({1'b0, i_in_data.floors} > (FLOORS_W+1)'(MAX_FLOORS)) begin
            floors_sat = ADDR_W'(MAX_FLOORS);
        end else begin
            floors_sat = ADDR_W'(i_in_data.floors);
        end
        bit_len = '0;
        for (int i = 0; i < ADDR_W; i++) begin
            if (floors_sat[i]) begin
                bit_len = K_W'(i + 1);
            end
        end
        if (i_in_data.phones > PHONES_W'(bit_len)) begin
            k_eff = PHONES_W'(bit_len);
        end else begin
            k_eff = i_in_data.phones;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_prev_bank <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_prev_bank <= n_prev_bank;
            r_out_valid <= n_out_valid;
        end
        r_n        <= n_n;
        r_k        <= n_k;
        r_p        <= n_p;
        r_f        <= n_f;
        r_split    <= n_split;
        r_tests    <= n_tests;
        r_imposs   <= n_imposs;
        r_out_data <= n_out_data;
    end

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_k         = r_k;
        n_p         = r_p;
        n_f         = r_f;
        n_split     = r_split;
        n_prev_bank = r_prev_bank;
        n_tests     = r_tests;
        n_imposs    = r_imposs;
        n_out_data  = r_out_data;
        // Drop the held result once the consumer takes it.
        n_out_valid = r_out_valid & i_out_stall;

        // Cell addresses: cur[f-s], cur[f-s-1], prev[s], prev[s+1].
        mem_ctl.we        = 1'b0;
        mem_ctl.wbank     = ~r_prev_bank;
        mem_ctl.waddr     = r_f;
        mem_ctl.wdata     = cell_value;
        mem_ctl.prev_bank = r_prev_bank;
        mem_ctl.cur_a0    = r_f - r_split;
        mem_ctl.cur_a1    = r_f - r_split - ADDR_W'(1);
        mem_ctl.prev_a0   = r_split;
        mem_ctl.prev_a1   = r_split + ADDR_W'(1);

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_n      = floors_sat;
                    n_k      = K_W'(k_eff);
                    n_f      = '0;
                    n_tests  = '0;
                    n_imposs = 1'b0;
                    if (floors_sat <= ADDR_W'(1)) begin
                        n_state = ST_DONE;
                    end else if (i_in_data.phones == '0) begin
                        n_imposs = 1'b1;
                        n_state  = ST_DONE;
                    end else begin
                        n_state = ST_INIT;
                    end
                end
            end
            ST_INIT: begin
                // One-phone row: prev[f] = f-1, prev[0] = 0.
                mem_ctl.we    = 1'b1;
                mem_ctl.wbank = r_prev_bank;
                mem_ctl.wdata = (r_f == '0) ? '0 : VAL_W'(r_f - ADDR_W'(1));
                if (r_f == r_n) begin
                    n_p = K_W'(2);
                    if (r_k == K_W'(1)) begin
                        n_state = ST_FIN_RD;
                    end else begin
                        n_state = ST_ROW0;
                    end
                end else begin
                    n_f = r_f + ADDR_W'(1);
                end
            end
            ST_ROW0: begin
                mem_ctl.we    = 1'b1;
                mem_ctl.waddr = '0;
                mem_ctl.wdata = '0;
                n_state       = ST_ROW1;
            end
            ST_ROW1: begin
                mem_ctl.we    = 1'b1;
                mem_ctl.waddr = ADDR_W'(1);
                mem_ctl.wdata = '0;
                n_f           = ADDR_W'(2);
                n_split       = ADDR_W'(1);
                n_state       = ST_CELL_RD;
            end
            ST_CELL_RD: begin
                // Addresses go out; data lands in the read registers.
                n_state = ST_CELL_WR;
            end
            ST_CELL_WR: begin
                mem_ctl.we = 1'b1;
                if (cell_step) begin
                    n_split = r_split + ADDR_W'(1);
                end
                if (r_f == r_n) begin
                    // Row done: swap roles of the banks.
                    n_prev_bank = ~r_prev_bank;
                    if (r_p == r_k) begin
                        n_state = ST_FIN_RD;
                    end else begin
                        n_p     = r_p + K_W'(1);
                        n_state = ST_ROW0;
                    end
                end else begin
                    n_f     = r_f + ADDR_W'(1);
                    n_state = ST_CELL_RD;
                end
            end
            ST_FIN_RD: begin
                mem_ctl.prev_a0 = r_n;
                n_state         = ST_FIN_CAP;
            end
            ST_FIN_CAP: begin
                n_tests  = mem_rsp.prev_d0;
                n_imposs = 1'b0;
                n_state  = ST_DONE;
            end
            ST_DONE: begin
                // Hold until the output register is free.
                if (!(r_out_valid && i_out_stall)) begin
                    n_out_valid           = 1'b1;
                    n_out_data.tests      = r_tests;
                    n_out_data.impossible = r_imposs;
                    n_state               = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
